>>> hw/rtl/dedup_fifo_queue_top_macros.svh
// Assertion macros used by the queue's checker file.
// Depends on nothing; the user supplies the clock and reset names.
`ifndef DEDUP_FIFO_QUEUE_TOP_MACROS_SVH
`define DEDUP_FIFO_QUEUE_TOP_MACROS_SVH

// Assert an implication, sampled on the rising clock edge, off during reset.
`define DFQ_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Assert that a condition at one edge forces another at the next edge.
`define DFQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/dfq_pkg.sv
// Shared types and constants of the duplicate-rejecting queue.
// Used by the controller, the datapath, the top level and the checker.
package dfq_pkg;

   // Queue size, the widths that follow from it, and the fixed value, status and occupancy widths
   localparam int CAPACITY = 16;
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int PTR_W    = IDX_W + 1;
   localparam int VAL_W    = 32;
   localparam int STAT_W   = 3;
   localparam int OCC_W    = 5;

   // Request codes
   localparam logic ACT_ENQUEUE = 1'b0;
   localparam logic ACT_DEQUEUE = 1'b1;

   // Result status codes
   typedef enum logic [STAT_W-1:0] {
      STAT_ENQUEUED  = 3'd0,
      STAT_DUPLICATE = 3'd1,
      STAT_FULL      = 3'd2,
      STAT_DEQUEUED  = 3'd3,
      STAT_EMPTY     = 3'd4
   } status_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic latch;   // capture the request fields
      logic exec;    // carry out the captured request and load the result
   } dfq_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic out_busy;   // result register holds a transaction that stays this cycle
   } dfq_stat_type;

endpackage

>>> hw/rtl/dfq_ctrl.sv
// Controller of the duplicate-rejecting queue: accepts a request, then
// issues one execute once the result register can take it. Uses dfq_pkg.
module dfq_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  dfq_pkg::dfq_stat_type stat,
   output dfq_pkg::dfq_cmd_type  cmd
);
   import dfq_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Decode state into handshake and commands
   always_comb begin
      state_in  = state_ff;
      req_stall = 1'b1;
      cmd       = '0;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (!stat.out_busy) begin
               cmd.exec = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Advance state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> hw/rtl/dfq_datapath.sv
// Datapath of the duplicate-rejecting queue: entry store, head/tail/count,
// parallel duplicate compare and the result register. Uses dfq_pkg.
module dfq_datapath (
   input  logic                         clock,
   input  logic                         reset,
   input  dfq_pkg::dfq_cmd_type          cmd,
   output dfq_pkg::dfq_stat_type         stat,
   input  logic                         req_action,
   input  logic signed [dfq_pkg::VAL_W-1:0] req_value,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [dfq_pkg::STAT_W-1:0]   rsp_status,
   output logic signed [dfq_pkg::VAL_W-1:0] rsp_out_value,
   output logic [dfq_pkg::OCC_W-1:0]    rsp_occupancy
);
   import dfq_pkg::*;

   // Captured request
   logic             act_ff;
   logic [VAL_W-1:0] val_ff;

   // Queue state
   logic [VAL_W-1:0] entries_ff [CAPACITY];
   logic [IDX_W-1:0] head_ff, head_in;
   logic [IDX_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;

   // Result register
   logic             rsp_valid_ff, rsp_valid_in;
   status_type       rsp_status_ff, rsp_status_in;
   logic [VAL_W-1:0] rsp_value_ff, rsp_value_in;
   logic [OCC_W-1:0] rsp_occ_ff, rsp_occ_in;

   logic [CAPACITY-1:0] held;
   logic [CAPACITY-1:0] match;
   logic                dup_hit;
   logic                wr_en;
   logic [PTR_W-1:0]    offset [CAPACITY];

   // Mark held slots by their distance from the head
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         if (IDX_W'(i) >= head_ff) begin
            offset[i] = PTR_W'(i) - {1'b0, head_ff};
         end else begin
            offset[i] = PTR_W'(i) + PTR_W'(CAPACITY) - {1'b0, head_ff};
         end
         held[i]  = (offset[i] < PTR_W'(count_ff));
         match[i] = held[i] && (entries_ff[i] == val_ff);
      end
   end

   assign dup_hit = |match;

   // Execute the captured request
   always_comb begin
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      wr_en         = 1'b0;
      rsp_status_in = STAT_EMPTY;
      rsp_value_in  = '0;
      if (act_ff == ACT_ENQUEUE) begin
         if (count_ff == CNT_W'(CAPACITY)) begin
            rsp_status_in = STAT_FULL;
         end else if (dup_hit) begin
            rsp_status_in = STAT_DUPLICATE;
         end else begin
            wr_en         = 1'b1;
            tail_in       = (tail_ff == IDX_W'(CAPACITY - 1)) ? '0 : tail_ff + 1'b1;
            count_in      = count_ff + 1'b1;
            rsp_status_in = STAT_ENQUEUED;
         end
      end else begin
         if (count_ff == '0) begin
            rsp_status_in = STAT_EMPTY;
         end else begin
            rsp_value_in  = entries_ff[head_ff];
            head_in       = (head_ff == IDX_W'(CAPACITY - 1)) ? '0 : head_ff + 1'b1;
            count_in      = count_ff - 1'b1;
            rsp_status_in = STAT_DEQUEUED;
         end
      end
      rsp_occ_in = OCC_W'(count_in);
   end

   // Hold the result until taken; load a new one on execute
   assign stat.out_busy = rsp_valid_ff && rsp_stall;
   assign rsp_valid_in  = cmd.exec || (rsp_valid_ff && rsp_stall);

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.exec) begin
            head_ff  <= head_in;
            tail_ff  <= tail_in;
            count_ff <= count_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         act_ff <= req_action;
         val_ff <= req_value;
      end
      if (cmd.exec) begin
         rsp_status_ff <= rsp_status_in;
         rsp_value_ff  <= rsp_value_in;
         rsp_occ_ff    <= rsp_occ_in;
      end
   end

   // Entry store write
   always_ff @(posedge clock) begin
      if (cmd.exec && wr_en) begin
         entries_ff[tail_ff] <= val_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_out_value = rsp_value_ff;
   assign rsp_occupancy = rsp_occ_ff;

endmodule

>>> hw/rtl/dedup_fifo_queue_top.sv
// Duplicate-rejecting FIFO queue of signed 32-bit values. A request is accepted when
// req_valid is high and req_stall low; it then waits in the execute state until the result
// register can take it, is checked against all held entries in one parallel compare, carried
// out, and its result loaded into the result register, which raises rsp_valid. No new request
// is accepted during the execute step. A new request is taken while an earlier result still
// waits in the result register; execution waits only while that register holds a stalled
// transaction. No clearing pass is needed after reset.
// Depends on dfq_pkg, dfq_ctrl and dfq_datapath.
module dedup_fifo_queue_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_action,
   input  logic signed [dfq_pkg::VAL_W-1:0]  req_value,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [dfq_pkg::STAT_W-1:0]        rsp_status,
   output logic signed [dfq_pkg::VAL_W-1:0]  rsp_out_value,
   output logic [dfq_pkg::OCC_W-1:0]         rsp_occupancy
);
   import dfq_pkg::*;

   dfq_cmd_type  cmd;
   dfq_stat_type stat;

   // Sequence each transaction
   dfq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Hold the queue and build results
   dfq_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .req_action    (req_action),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_status    (rsp_status),
      .rsp_out_value (rsp_out_value),
      .rsp_occupancy (rsp_occupancy)
   );

endmodule

>>> hw/rtl/dfq_checker.sv
// Port-level checker for the duplicate-rejecting queue, bound to the top level.
// Depends on dfq_pkg and dedup_fifo_queue_top_macros.svh.
`include "dedup_fifo_queue_top_macros.svh"

module dfq_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_stall,
   input logic                             rsp_valid,
   input logic                             rsp_stall,
   input logic [dfq_pkg::STAT_W-1:0]       rsp_status,
   input logic signed [dfq_pkg::VAL_W-1:0] rsp_out_value,
   input logic [dfq_pkg::OCC_W-1:0]        rsp_occupancy
);
   import dfq_pkg::*;

   // A stalled result stays offered
   `DFQ_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid, "rsp dropped while stalled")

   // One transaction at a time: stall right after an accept
   `DFQ_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_valid && !req_stall, req_stall, "second request taken during execute")

   // Only a dequeue carries a value
   `DFQ_ASSERT_IMPL(a_value_zero, clock, reset, rsp_valid && rsp_status != STAT_DEQUEUED, rsp_out_value == '0, "nonzero value without dequeue")

   // Empty reports no entries
   `DFQ_ASSERT_IMPL(a_empty_occ, clock, reset, rsp_valid && rsp_status == STAT_EMPTY, rsp_occupancy == '0, "empty status with entries held")

   // Full reports a full count
   `DFQ_ASSERT_IMPL(a_full_occ, clock, reset, rsp_valid && rsp_status == STAT_FULL, rsp_occupancy == OCC_W'(CAPACITY), "full status below capacity")

endmodule

bind dedup_fifo_queue_top dfq_checker u_dfq_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_status    (rsp_status),
   .rsp_out_value (rsp_out_value),
   .rsp_occupancy (rsp_occupancy)
);
